// ===== rtl/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg
// Shared constants, types and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int NumSlabs   = 16;
  localparam int MaxObjects = 64;
  localparam int SlabW      = $clog2(NumSlabs);
  localparam int ObjW       = $clog2(MaxObjects);
  localparam int SLinkW     = SlabW + 1;
  localparam int OLinkW     = ObjW + 1;
  localparam int CntW       = 7;
  localparam int LimW       = 5;
  localparam int ObjAddrW   = SlabW + ObjW;

  localparam logic [SLinkW-1:0] SNil = SLinkW'(NumSlabs);
  localparam logic [OLinkW-1:0] ONil = OLinkW'(MaxObjects);

  localparam logic [CntW-1:0] CountReset = 7'd8;
  localparam logic [LimW-1:0] LimitReset = 5'd16;

  localparam logic CfgIdxW = 1'b0;

  typedef enum logic [1:0] {
    TagUnused  = 2'd0,
    TagEmpty   = 2'd1,
    TagPartial = 2'd2,
    TagFull    = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatNoSlab  = 2'd1,
    StatBadFree = 2'd2
  } status_e;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StDecide,
    StGrow,
    StRead,
    StApply,
    StOut
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch_in;   // capture the input item
    logic decide;     // pick slab, check free, issue object read
    logic grow_init;  // start a grow sweep
    logic grow_step;  // write one object entry of the new slab
    logic grow_done;  // push the new slab on the empty list
    logic apply;      // update slab state and lists
    logic out_load;   // load the result register
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_free;
    logic need_grow;
    logic no_slab;
    logic grow_last;
  } sts_t;

endpackage

// ===== rtl/soa_ram.sv =====
// ----------------------------------------------------------------------------
// soa_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module soa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/soa_datapath.sv =====
// ----------------------------------------------------------------------------
// soa_datapath
// Slab state, list links, object memory and result register.
// ----------------------------------------------------------------------------
module soa_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  soa_pkg::ctl_t             ctl_i,
  output soa_pkg::sts_t             sts_o,
  input  logic                      cmd_i,
  input  logic [3:0]                free_slab_i,
  input  logic [5:0]                free_index_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic                      cfg_index_i,
  input  logic [6:0]                cfg_data_i,
  output logic [1:0]                status_o,
  output logic [3:0]                got_slab_o,
  output logic [5:0]                got_index_o,
  output logic [6:0]                slab_fill_o
);

  localparam int SW  = soa_pkg::SlabW;
  localparam int OW  = soa_pkg::ObjW;
  localparam int SLW = soa_pkg::SLinkW;
  localparam int OLW = soa_pkg::OLinkW;
  localparam int CW  = soa_pkg::CntW;
  localparam int NS  = soa_pkg::NumSlabs;

  // Configuration.
  logic [CW-1:0] count_q;
  logic [soa_pkg::LimW-1:0] limit_q;
  logic [CW-1:0] eff_cnt;
  logic [SLW-1:0] eff_lim;

  always_comb begin
    if (count_q == '0) begin
      eff_cnt = CW'(1);
    end else if (count_q > CW'(soa_pkg::MaxObjects)) begin
      eff_cnt = CW'(soa_pkg::MaxObjects);
    end else begin
      eff_cnt = count_q;
    end
    if (SLW'(limit_q) > SLW'(NS)) begin
      eff_lim = SLW'(NS);
    end else begin
      eff_lim = SLW'(limit_q);
    end
  end

  // Per-slab state.
  soa_pkg::tag_e    tag_q  [NS];
  logic [SLW-1:0]   next_q [NS];
  logic [SLW-1:0]   prev_q [NS];
  logic [CW-1:0]    use_q  [NS];
  logic [OLW-1:0]   fhead_q[NS];
  logic [SLW-1:0]   empty_head_q, partial_head_q, full_head_q;
  logic [SLW-1:0]   grown_q;

  // Latched item.
  logic             cmd_q;
  logic [SW-1:0]    fslab_q;
  logic [OW-1:0]    findex_q;
  logic [SW-1:0]    sel_q;     // slab touched by this item
  logic [OW-1:0]    obj_q;     // object touched by this item
  logic [OW:0]      gcnt_q;    // grow sweep counter
  soa_pkg::status_e stat_q;    // status of the item, loaded with the result

  // Object memory: {taken, next_free}.
  logic                   ram_we;
  logic [soa_pkg::ObjAddrW-1:0] ram_waddr, ram_raddr;
  logic [OLW:0]           ram_wdata, ram_rdata;

  soa_ram #(
    .Width(OLW + 1),
    .Depth(NS * soa_pkg::MaxObjects)
  ) u_obj_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Decide phase, combinational.
  logic          alloc_has;
  logic [SW-1:0] alloc_slab;
  logic          free_bad;
  logic          can_grow;

  always_comb begin
    alloc_has  = 1'b1;
    alloc_slab = '0;
    if (partial_head_q < SLW'(NS)) begin
      alloc_slab = partial_head_q[SW-1:0];
    end else if (empty_head_q < SLW'(NS)) begin
      alloc_slab = empty_head_q[SW-1:0];
    end else begin
      alloc_has = 1'b0;
    end
    can_grow = (grown_q < eff_lim) && (grown_q < SLW'(NS));
    free_bad = (tag_q[fslab_q] == soa_pkg::TagUnused) ||
               (CW'(findex_q) >= eff_cnt);
  end

  assign sts_o.is_free   = cmd_q;
  assign sts_o.need_grow = !alloc_has;
  assign sts_o.no_slab   = !alloc_has && !can_grow;
  assign sts_o.grow_last = (gcnt_q == (OW+1)'(soa_pkg::MaxObjects - 1));

  // Allocated object comes from the slab free head; freed object is the input.
  logic [OLW-1:0] head_sel;
  assign head_sel = fhead_q[alloc_slab];

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {sel_q, obj_q};
    ram_wdata = '0;
    ram_raddr = {sel_q, obj_q};
    if (ctl_i.grow_step) begin
      ram_we    = 1'b1;
      ram_waddr = {grown_q[SW-1:0], gcnt_q[OW-1:0]};
      // Entry i links to i-1; entry 0 and entries past the count end the list.
      if ((CW'(gcnt_q) < eff_cnt) && (gcnt_q != '0)) begin
        ram_wdata = {1'b0, OLW'(gcnt_q - 1'b1)};
      end else begin
        ram_wdata = {1'b0, soa_pkg::ONil};
      end
    end else if (ctl_i.apply) begin
      if (cmd_q == soa_pkg::CmdFree) begin
        if (ram_rdata[OLW] && !free_bad) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, fhead_q[sel_q]};
        end
      end else begin
        ram_we    = 1'b1;
        ram_wdata = {1'b1, soa_pkg::ONil};
      end
    end
    if (ctl_i.decide) begin
      if (cmd_q == soa_pkg::CmdAlloc) begin
        ram_raddr = {alloc_slab, head_sel[OW-1:0]};
      end else begin
        ram_raddr = {fslab_q, findex_q};
      end
    end
  end

  // Free validity needs the taken bit, which arrives in the apply cycle.
  logic free_ok;
  assign free_ok = (cmd_q == soa_pkg::CmdFree) && !free_bad && ram_rdata[OLW];

  // New fill and target tag.
  logic [CW-1:0]  new_use;
  soa_pkg::tag_e  new_tag;

  always_comb begin
    if (cmd_q == soa_pkg::CmdAlloc) begin
      new_use = use_q[sel_q] + 1'b1;
      new_tag = (new_use >= eff_cnt) ? soa_pkg::TagFull : soa_pkg::TagPartial;
    end else begin
      new_use = (use_q[sel_q] != '0) ? use_q[sel_q] - 1'b1 : '0;
      new_tag = (new_use == '0) ? soa_pkg::TagEmpty : soa_pkg::TagPartial;
    end
  end

  function automatic logic [SLW-1:0] head_for(soa_pkg::tag_e t, logic [SLW-1:0] e,
                                              logic [SLW-1:0] p, logic [SLW-1:0] f);
    logic [SLW-1:0] r;
    unique case (t)
      soa_pkg::TagEmpty:   r = e;
      soa_pkg::TagPartial: r = p;
      default:             r = f;
    endcase
    return r;
  endfunction

  // Sequential state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [SLW-1:0] eh, ph, fh, n, p, h;
    logic [SW-1:0]  s;
    if (!rst_ni) begin
      count_q        <= soa_pkg::CountReset;
      limit_q        <= soa_pkg::LimitReset;
      empty_head_q   <= soa_pkg::SNil;
      partial_head_q <= soa_pkg::SNil;
      full_head_q    <= soa_pkg::SNil;
      grown_q        <= '0;
      cmd_q          <= 1'b0;
      fslab_q        <= '0;
      findex_q       <= '0;
      sel_q          <= '0;
      obj_q          <= '0;
      gcnt_q         <= '0;
      stat_q         <= soa_pkg::StatOk;
      status_o       <= '0;
      got_slab_o     <= '0;
      got_index_o    <= '0;
      slab_fill_o    <= '0;
      for (int i = 0; i < NS; i++) begin
        tag_q[i]   <= soa_pkg::TagUnused;
        next_q[i]  <= soa_pkg::SNil;
        prev_q[i]  <= soa_pkg::SNil;
        use_q[i]   <= '0;
        fhead_q[i] <= soa_pkg::ONil;
      end
    end else begin
      eh = empty_head_q;
      ph = partial_head_q;
      fh = full_head_q;
      s  = sel_q;

      if (cfg_valid_i && cfg_ready_i && grown_q == '0) begin
        if (cfg_index_i == soa_pkg::CfgIdxW) begin
          count_q <= cfg_data_i;
        end else begin
          limit_q <= cfg_data_i[soa_pkg::LimW-1:0];
        end
      end

      if (ctl_i.latch_in) begin
        cmd_q    <= cmd_i;
        fslab_q  <= free_slab_i;
        findex_q <= free_index_i;
      end

      if (ctl_i.decide) begin
        if (cmd_q == soa_pkg::CmdAlloc) begin
          sel_q <= alloc_slab;
          obj_q <= head_sel[OW-1:0];
        end else begin
          sel_q <= fslab_q;
          obj_q <= findex_q;
        end
        if (cmd_q == soa_pkg::CmdAlloc && !alloc_has && !can_grow) begin
          stat_q <= soa_pkg::StatNoSlab;
        end else begin
          stat_q <= soa_pkg::StatOk;
        end
      end

      if (ctl_i.grow_init) begin
        gcnt_q <= '0;
      end
      if (ctl_i.grow_step) begin
        gcnt_q <= gcnt_q + 1'b1;
      end
      if (ctl_i.grow_done) begin
        s = grown_q[SW-1:0];
        use_q[s]   <= '0;
        fhead_q[s] <= OLW'(eff_cnt - 1'b1);
        next_q[s]  <= eh;
        prev_q[s]  <= soa_pkg::SNil;
        if (eh < SLW'(NS)) begin
          prev_q[eh[SW-1:0]] <= SLW'(s);
        end
        empty_head_q <= SLW'(s);
        tag_q[s]     <= soa_pkg::TagEmpty;
        grown_q      <= grown_q + 1'b1;
        sel_q        <= s;
        obj_q        <= OW'(eff_cnt - 1'b1);
      end

      if (ctl_i.apply && cmd_q == soa_pkg::CmdFree && !free_ok) begin
        stat_q <= soa_pkg::StatBadFree;
      end

      if (ctl_i.apply && (cmd_q == soa_pkg::CmdAlloc || free_ok)) begin
        use_q[s] <= new_use;
        if (cmd_q == soa_pkg::CmdAlloc) begin
          fhead_q[s] <= ram_rdata[OLW-1:0];
        end else begin
          fhead_q[s] <= OLW'(obj_q);
        end
        if (tag_q[s] != new_tag) begin
          n = next_q[s];
          p = prev_q[s];
          // Unlink from the current list.
          if (p < SLW'(NS)) begin
            next_q[p[SW-1:0]] <= n;
          end else begin
            unique case (tag_q[s])
              soa_pkg::TagEmpty:   eh = n;
              soa_pkg::TagPartial: ph = n;
              default:             fh = n;
            endcase
          end
          if (n < SLW'(NS)) begin
            prev_q[n[SW-1:0]] <= p;
          end
          // Push at the head of the target list.
          h = head_for(new_tag, eh, ph, fh);
          next_q[s] <= h;
          prev_q[s] <= soa_pkg::SNil;
          if (h < SLW'(NS)) begin
            prev_q[h[SW-1:0]] <= SLW'(s);
          end
          unique case (new_tag)
            soa_pkg::TagEmpty:   eh = SLW'(s);
            soa_pkg::TagPartial: ph = SLW'(s);
            default:             fh = SLW'(s);
          endcase
          tag_q[s]       <= new_tag;
          empty_head_q   <= eh;
          partial_head_q <= ph;
          full_head_q    <= fh;
        end
      end

      if (ctl_i.out_load) begin
        status_o <= stat_q;
        if (stat_q == soa_pkg::StatOk && cmd_q == soa_pkg::CmdAlloc) begin
          got_slab_o  <= sel_q;
          got_index_o <= obj_q;
        end else begin
          got_slab_o  <= '0;
          got_index_o <= '0;
        end
        if (stat_q == soa_pkg::StatOk) begin
          slab_fill_o <= use_q[sel_q];
        end else begin
          slab_fill_o <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/soa_ctrl.sv =====
// ----------------------------------------------------------------------------
// soa_ctrl
// Sequencer for one allocate or free: decide, optional grow and read-back, apply, output.
// ----------------------------------------------------------------------------
module soa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          cfg_ready_o,
  output soa_pkg::ctl_t ctl_o,
  input  soa_pkg::sts_t sts_i
);

  soa_pkg::state_e state_q, state_d;
  logic            valid_q, valid_d;
  logic            load_ok;

  // The result register is free when empty or being taken this cycle.
  assign load_ok = !valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      soa_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = soa_pkg::StDecide;
        end
      end
      soa_pkg::StDecide: begin
        if (sts_i.is_free) begin
          state_d = soa_pkg::StApply;
        end else if (sts_i.no_slab) begin
          state_d = soa_pkg::StOut;
        end else if (sts_i.need_grow) begin
          state_d = soa_pkg::StGrow;
        end else begin
          state_d = soa_pkg::StApply;
        end
      end
      soa_pkg::StGrow: begin
        if (sts_i.grow_last) begin
          state_d = soa_pkg::StRead;
        end
      end
      soa_pkg::StRead:  state_d = soa_pkg::StApply;
      soa_pkg::StApply: state_d = soa_pkg::StOut;
      soa_pkg::StOut: begin
        if (load_ok) begin
          state_d = soa_pkg::StIdle;
        end
      end
      default:          state_d = soa_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = (state_q == soa_pkg::StIdle);
    valid_d    = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      soa_pkg::StIdle:   ctl_o.latch_in = in_valid_i;
      soa_pkg::StDecide: begin
        ctl_o.decide    = 1'b1;
        ctl_o.grow_init = 1'b1;
      end
      soa_pkg::StGrow: begin
        ctl_o.grow_step = 1'b1;
        ctl_o.grow_done = sts_i.grow_last;
      end
      soa_pkg::StRead:   ;
      soa_pkg::StApply: begin
        ctl_o.apply    = 1'b1;
      end
      soa_pkg::StOut: begin
        // Hold the finished item until the result register frees up.
        if (load_ok) begin
          ctl_o.out_load = 1'b1;
          valid_d        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = valid_q;
  assign cfg_ready_o = (state_q == soa_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= soa_pkg::StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/slab_object_allocator_top.sv =====
// ----------------------------------------------------------------------------
// slab_object_allocator_top
// Object allocator over sixteen slabs with empty, partial and full lists.
// ----------------------------------------------------------------------------
// After an item is accepted it passes through decide and apply, and its
// result is then loaded; the next item is accepted back in idle, so a new
// item is taken only once the last one is through. An allocate that grows a
// new slab first writes all 64 object entries of that slab into the object
// memory, then reads back the new free head. One item is in flight at a
// time; a new item is accepted while the previous result still waits, but
// its result is held until the result register is taken. Configuration
// writes are taken while idle and ignored once any slab has been grown.
module slab_object_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [3:0] free_slab_i,
  input  logic [5:0] free_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [3:0] got_slab_o,
  output logic [5:0] got_index_o,
  output logic [6:0] slab_fill_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  soa_pkg::ctl_t ctl;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_ready_o(cfg_ready_o),
    .ctl_o      (ctl),
    .sts_i      (sts)
  );

  soa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cmd_i       (cmd_i),
    .free_slab_i (free_slab_i),
    .free_index_i(free_index_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_o    (status_o),
    .got_slab_o  (got_slab_o),
    .got_index_o (got_index_o),
    .slab_fill_o (slab_fill_o)
  );

endmodule
